// File: rtl/wac_pkg.sv
package wac_pkg;

	localparam int CNT_W = 8;
	localparam int DIST_W = 15;
	localparam int CFG_W = 14;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef logic signed [DIST_W-1:0] dist_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam logic [1:0] REG_TAP_WINDOW_TICKS = 2'd0;
	localparam logic [1:0] REG_FALL_JUMP        = 2'd1;
	localparam logic [1:0] REG_STILL_BAND       = 2'd2;
	localparam logic [1:0] REG_IDLE_LIMIT       = 2'd3;

	localparam logic FUNC_TAP  = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	localparam logic [1:0] EV_NONE      = 2'd0;
	localparam logic [1:0] EV_ENGAGED   = 2'd1;
	localparam logic [1:0] EV_IDLE      = 2'd2;
	localparam logic [1:0] EV_DISENGAGE = 2'd3;

	localparam logic [1:0] OBST_NONE    = 2'd0;
	localparam logic [1:0] OBST_QUARTER = 2'd1;
	localparam logic [1:0] OBST_HALF    = 2'd2;
	localparam logic [1:0] OBST_FULL    = 2'd3;

	localparam logic [2:0] LEDGE_NONE    = 3'd0;
	localparam logic [2:0] LEDGE_QUARTER = 3'd1;
	localparam logic [2:0] LEDGE_HALF    = 3'd2;
	localparam logic [2:0] LEDGE_FULL    = 3'd3;
	localparam logic [2:0] LEDGE_SIREN   = 3'd4;

	localparam dist_t OBST_FAR  = 15'sd480;
	localparam dist_t OBST_MID  = 15'sd320;
	localparam dist_t OBST_NEAR = 15'sd160;

	localparam dist_t LEDGE_SIREN_MIN   = 15'sd288;
	localparam dist_t LEDGE_FULL_MIN    = 15'sd160;
	localparam dist_t LEDGE_HALF_MIN    = 15'sd80;
	localparam dist_t LEDGE_QUARTER_MIN = 15'sd48;

	localparam logic [9:0] DISP_MAX = 10'd999;

	localparam logic [7:0]       RST_TAP_WINDOW_TICKS = 8'd40;
	localparam logic [CFG_W-1:0] RST_FALL_JUMP        = 14'd320;
	localparam logic [CFG_W-1:0] RST_STILL_BAND       = 14'd32;
	localparam logic [7:0]       RST_IDLE_LIMIT       = 8'd50;

	typedef struct packed {
		logic [7:0]       tap_window_ticks;
		logic [CFG_W-1:0] fall_jump;
		logic [CFG_W-1:0] still_band;
		logic [7:0]       idle_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0] obstacle_level;
		logic [2:0] ledge_level;
		logic       display_update;
		logic [9:0] ahead_display;
		logic [9:0] ground_display;
	} alert_t;

	typedef struct packed {
		logic       assist_on;
		logic [1:0] mode_event;
		alert_t     alert;
		logic [7:0] taps_seen;
	} result_t;

endpackage

// File: rtl/wac_cfg_regs.sv
module wac_cfg_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [wac_pkg::CFG_W-1:0] cfg_data,
	output wac_pkg::cfg_t            cfg
);
	import wac_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_window_ticks <= RST_TAP_WINDOW_TICKS;
			cfg_q.fall_jump        <= RST_FALL_JUMP;
			cfg_q.still_band       <= RST_STILL_BAND;
			cfg_q.idle_limit       <= RST_IDLE_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TAP_WINDOW_TICKS: cfg_q.tap_window_ticks <= cfg_data[7:0];
				REG_FALL_JUMP:        cfg_q.fall_jump <= cfg_data;
				REG_STILL_BAND:       cfg_q.still_band <= cfg_data;
				REG_IDLE_LIMIT:       cfg_q.idle_limit <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/wac_alert.sv
module wac_alert (
	input  wac_pkg::dist_t  ahead,
	input  wac_pkg::dist_t  ground,
	input  logic            assist,
	output wac_pkg::alert_t alert
);
	import wac_pkg::*;

	function automatic logic [9:0] to_display(input dist_t d);
		logic [10:0] whole;
		begin
			whole = 11'(d >>> 4);
			if (d < 0)
				to_display = 10'd0;
			else if (whole > 11'(DISP_MAX))
				to_display = DISP_MAX;
			else
				to_display = whole[9:0];
		end
	endfunction

	logic [1:0] obst;
	logic [2:0] ledge;

	always_comb begin
		obst = OBST_NONE;
		if (ahead > 0 && ahead <= OBST_FAR) begin
			if (ahead > OBST_MID)
				obst = OBST_QUARTER;
			else if (ahead > OBST_NEAR)
				obst = OBST_HALF;
			else
				obst = OBST_FULL;
		end

		if (ground >= LEDGE_SIREN_MIN)
			ledge = LEDGE_SIREN;
		else if (ground >= LEDGE_FULL_MIN)
			ledge = LEDGE_FULL;
		else if (ground >= LEDGE_HALF_MIN)
			ledge = LEDGE_HALF;
		else if (ground >= LEDGE_QUARTER_MIN)
			ledge = LEDGE_QUARTER;
		else
			ledge = LEDGE_NONE;

		if (assist) begin
			alert = '0;
		end else begin
			alert.obstacle_level = obst;
			alert.ledge_level    = ledge;
			alert.display_update = 1'b1;
			alert.ahead_display  = to_display(ahead);
			alert.ground_display = to_display(ground);
		end
	end

endmodule

// File: rtl/wac_core.sv
module wac_core (
	input  logic             clk,
	input  logic             arst_n,
	input  wac_pkg::cfg_t    cfg,
	input  logic             fire,
	input  logic             func,
	input  wac_pkg::dist_t   ahead,
	input  wac_pkg::dist_t   ground,
	output wac_pkg::result_t result
);
	import wac_pkg::*;

	cnt_t       tap_total_q;
	logic       window_open_q;
	logic [7:0] window_timer_q;
	logic       assist_q;
	cnt_t       idle_steps_q;
	dist_t      prev_ahead_q;
	dist_t      prev_ground_q;

	cnt_t       tap_total_n;
	logic       window_open_n;
	logic [7:0] window_timer_n;
	logic       assist_n;
	cnt_t       idle_steps_n;
	logic [7:0] timer_inc;
	logic       closed;
	logic [1:0] event_code;
	logic [15:0] taps_wide;
	logic signed [15:0] diff_a;
	logic signed [15:0] diff_g;
	logic [15:0] abs_a;
	logic [15:0] abs_g;
	logic       fall;
	logic       still;
	alert_t     alert;

	assign diff_a = {ahead[DIST_W-1], ahead} - {prev_ahead_q[DIST_W-1], prev_ahead_q};
	assign diff_g = {ground[DIST_W-1], ground} - {prev_ground_q[DIST_W-1], prev_ground_q};
	assign abs_a  = diff_a[15] ? 16'(-diff_a) : 16'(diff_a);
	assign abs_g  = diff_g[15] ? 16'(-diff_g) : 16'(diff_g);
	assign fall   = (abs_a > 16'(cfg.fall_jump)) || (abs_g > 16'(cfg.fall_jump));
	assign still  = (abs_a < 16'(cfg.still_band)) && (abs_g < 16'(cfg.still_band));
	assign timer_inc = window_timer_q + 8'd1;

	always_comb begin
		tap_total_n    = tap_total_q;
		window_open_n  = window_open_q;
		window_timer_n = window_timer_q;
		assist_n       = assist_q;
		idle_steps_n   = idle_steps_q;
		closed         = 1'b0;
		event_code     = EV_NONE;
		taps_wide      = 16'd0;

		if (func == FUNC_TAP) begin
			if (!window_open_q) begin
				tap_total_n   = cnt_t'(1);
				window_open_n = 1'b1;
			end else if (tap_total_q != CNT_MAX) begin
				tap_total_n = tap_total_q + cnt_t'(1);
			end
			window_timer_n = 8'd0;
		end else begin
			if (window_open_q) begin
				if (timer_inc >= cfg.tap_window_ticks) begin
					closed         = 1'b1;
					window_open_n  = 1'b0;
					window_timer_n = 8'd0;
				end else begin
					window_timer_n = timer_inc;
				end
			end

			if (closed) begin
				taps_wide   = 16'(tap_total_q);
				tap_total_n = '0;
				if (fall) begin
					assist_n   = 1'b1;
					event_code = EV_ENGAGED;
				end else if (taps_wide <= 16'd2 && !assist_q) begin
					assist_n   = 1'b1;
					event_code = EV_ENGAGED;
				end else if (taps_wide >= 16'd3 && assist_q) begin
					assist_n   = 1'b0;
					event_code = EV_DISENGAGE;
				end
			end

			if (still) begin
				if (idle_steps_q != CNT_MAX)
					idle_steps_n = idle_steps_q + cnt_t'(1);
			end else begin
				idle_steps_n = '0;
			end

			if (16'(idle_steps_n) >= 16'(cfg.idle_limit) && !assist_n) begin
				assist_n     = 1'b1;
				event_code   = EV_IDLE;
				idle_steps_n = '0;
			end
		end
	end

	wac_alert u_alert (
		.ahead  (ahead),
		.ground (ground),
		.assist (assist_n),
		.alert  (alert)
	);

	always_comb begin
		result.assist_on  = assist_n;
		result.mode_event = event_code;
		result.alert      = alert;
		result.taps_seen  = (taps_wide > 16'd255) ? 8'hFF : taps_wide[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_total_q    <= '0;
			window_open_q  <= 1'b0;
			window_timer_q <= 8'd0;
			assist_q       <= 1'b0;
			idle_steps_q   <= '0;
			prev_ahead_q   <= '0;
			prev_ground_q  <= '0;
		end else if (fire) begin
			tap_total_q    <= tap_total_n;
			window_open_q  <= window_open_n;
			window_timer_q <= window_timer_n;
			assist_q       <= assist_n;
			idle_steps_q   <= idle_steps_n;
			if (func == FUNC_STEP) begin
				prev_ahead_q  <= ahead;
				prev_ground_q <= ground;
			end
		end
	end

endmodule

// File: rtl/walking_aid_alert_controller.sv
// Walking-aid alert controller. Tap items (func 0) open or extend the tap window and give
// no result; step items (func 1) give exactly one result each. Every item is held in one
// input register and its whole effect on mode, counters and alerts is worked out from there
// combinationally, so the block takes one item per clock as long as out_stall allows, with
// an output register that holds a finished result while the next item is accepted. A step
// item is captured in the input register and its result is then registered in the output
// register, raising out_valid, once that register is free. Configuration writes through
// cfg_we, cfg_index and cfg_data are registered in wac_cfg_regs and must be made while idle.
module walking_aid_alert_controller (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [wac_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      func,
	input  wac_pkg::dist_t            ahead_distance,
	input  wac_pkg::dist_t            ground_distance,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      assist_on,
	output logic [1:0]                mode_event,
	output logic [1:0]                obstacle_level,
	output logic [2:0]                ledge_level,
	output logic                      display_update,
	output logic [9:0]                ahead_display,
	output logic [9:0]                ground_display,
	output logic [7:0]                taps_seen
);
	import wac_pkg::*;

	cfg_t    cfg;
	logic    valid_s1;
	logic    func_s1;
	dist_t   ahead_s1;
	dist_t   ground_s1;
	logic    out_valid_q;
	result_t result_q;
	result_t result;
	logic    out_free;
	logic    advance;
	logic    accept;

	wac_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && ((func_s1 == FUNC_TAP) || out_free);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1   <= func;
			ahead_s1  <= ahead_distance;
			ground_s1 <= ground_distance;
		end
	end

	wac_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (advance),
		.func   (func_s1),
		.ahead  (ahead_s1),
		.ground (ground_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && func_s1 == FUNC_STEP) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && func_s1 == FUNC_STEP)
			result_q <= result;
	end

	assign out_valid      = out_valid_q;
	assign assist_on      = result_q.assist_on;
	assign mode_event     = result_q.mode_event;
	assign obstacle_level = result_q.alert.obstacle_level;
	assign ledge_level    = result_q.alert.ledge_level;
	assign display_update = result_q.alert.display_update;
	assign ahead_display  = result_q.alert.ahead_display;
	assign ground_display = result_q.alert.ground_display;
	assign taps_seen      = result_q.taps_seen;

endmodule

// File: tb/tb_walking_aid_alert_controller.sv
`timescale 1ns / 1ps

module tb_walking_aid_alert_controller;
	import wac_pkg::*;

	localparam int N_PHASES = 8;
	localparam int PHASE_ITEMS = 100;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 4;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic             f;
		dist_t            a;
		dist_t            g;
		logic [1:0]       idx;
		logic [CFG_W-1:0] val;
		logic             pin;
		result_t          res;
	} plan_row_t;

	localparam result_t ALL_CLEAR = '{assist_on: 1'b0, mode_event: EV_NONE,
		alert: '{obstacle_level: OBST_NONE, ledge_level: LEDGE_NONE, display_update: 1'b1,
		ahead_display: 10'd0, ground_display: 10'd0}, taps_seen: 8'd0};
	localparam result_t FAR_CLAMP = '{assist_on: 1'b0, mode_event: EV_NONE,
		alert: '{obstacle_level: OBST_NONE, ledge_level: LEDGE_SIREN, display_update: 1'b1,
		ahead_display: DISP_MAX, ground_display: DISP_MAX}, taps_seen: 8'd0};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = REG_TAP_WINDOW_TICKS;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             func = FUNC_TAP;
	dist_t            ahead_distance = '0;
	dist_t            ground_distance = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             assist_on;
	logic [1:0]       mode_event;
	logic [1:0]       obstacle_level;
	logic [2:0]       ledge_level;
	logic             display_update;
	logic [9:0]       ahead_display;
	logic [9:0]       ground_display;
	logic [7:0]       taps_seen;

	logic    pin_en = 1'b0;
	result_t pin_res = '0;

	cfg_t  regs = '{RST_TAP_WINDOW_TICKS, RST_FALL_JUMP, RST_STILL_BAND, RST_IDLE_LIMIT};
	cnt_t  win_taps = '0;
	logic  win_open = 1'b0;
	logic [7:0] win_age = '0;
	logic  assist = 1'b0;
	cnt_t  still_run = '0;
	dist_t last_a = '0;
	dist_t last_g = '0;

	result_t alert_q[$];
	bit gaps_on = 1'b1;
	bit stall_on = 1'b1;
	int stall_left = 0;
	int cycles = 0;
	int n_steps = 0;
	int n_taps = 0;
	int n_checked = 0;
	int n_bad = 0;
	int n_settings = 0;
	int n_engaged = 0;
	int n_idle = 0;
	int n_released = 0;

	plan_row_t plan [0:26] = '{
		'{ROW_ITEM, FUNC_STEP, 15'sd0, 15'sd0, REG_TAP_WINDOW_TICKS, 14'd0, 1'b1, ALL_CLEAR},
		'{ROW_ITEM, FUNC_STEP, 15'sd16383, 15'sd16383, REG_TAP_WINDOW_TICKS, 14'd0, 1'b1,
			FAR_CLAMP},
		'{ROW_ITEM, FUNC_STEP, -15'sd16, -15'sd16, REG_TAP_WINDOW_TICKS, 14'd0, 1'b1, ALL_CLEAR},
		'{ROW_ITEM, FUNC_STEP, 15'sd481, 15'sd287, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_STEP, 15'sd480, 15'sd159, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_STEP, 15'sd320, 15'sd79, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_STEP, 15'sd161, 15'sd48, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_STEP, 15'sd160, 15'sd47, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_STEP, 15'sd1, 15'sd288, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_REG, FUNC_TAP, 15'sd0, 15'sd0, REG_TAP_WINDOW_TICKS, 14'd2, 1'b0, '0},
		'{ROW_ITEM, FUNC_TAP, 15'sd100, 15'sd200, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_STEP, 15'sd200, 15'sd100, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_STEP, 15'sd200, 15'sd100, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_TAP, 15'sd0, 15'sd0, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_TAP, 15'sd16383, -15'sd16, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_TAP, -15'sd16, 15'sd16383, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_STEP, 15'sd200, 15'sd100, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_STEP, 15'sd200, 15'sd100, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_TAP, 15'sd50, 15'sd50, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_STEP, 15'sd200, 15'sd100, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_STEP, 15'sd10000, 15'sd100, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_REG, FUNC_TAP, 15'sd0, 15'sd0, REG_IDLE_LIMIT, 14'd1, 1'b0, '0},
		'{ROW_ITEM, FUNC_TAP, 15'sd7, 15'sd9, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_TAP, 15'sd8, 15'sd10, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_TAP, 15'sd9, 15'sd11, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_STEP, 15'sd10000, 15'sd100, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0},
		'{ROW_ITEM, FUNC_STEP, 15'sd10000, 15'sd100, REG_TAP_WINDOW_TICKS, 14'd0, 1'b0, '0}
	};

	walking_aid_alert_controller u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.ahead_distance (ahead_distance),
		.ground_distance(ground_distance),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.assist_on      (assist_on),
		.mode_event     (mode_event),
		.obstacle_level (obstacle_level),
		.ledge_level    (ledge_level),
		.display_update (display_update),
		.ahead_display  (ahead_display),
		.ground_display (ground_display),
		.taps_seen      (taps_seen)
	);

	always #5 clk = ~clk;

	function automatic logic [9:0] shown_cm(input dist_t d);
		int v;
		v = int'(d) >>> 4;
		if (d < 0)
			return '0;
		if (v > int'(DISP_MAX))
			return DISP_MAX;
		return v[9:0];
	endfunction

	function automatic bit predict_alert(input logic f, input dist_t a, input dist_t g,
			output result_t r);
		int da;
		int dg;
		logic closed;
		cnt_t taps;
		r = '0;
		closed = 1'b0;
		taps = '0;
		if (f == FUNC_TAP) begin
			if (!win_open) begin
				win_taps = 1;
				win_open = 1'b1;
			end else if (win_taps != CNT_MAX) begin
				win_taps = win_taps + 1'b1;
			end
			win_age = '0;
			return 1'b0;
		end
		if (win_open) begin
			win_age = win_age + 1'b1;
			if (win_age >= regs.tap_window_ticks) begin
				closed = 1'b1;
				win_open = 1'b0;
				win_age = '0;
			end
		end
		da = int'(a) - int'(last_a);
		if (da < 0)
			da = -da;
		dg = int'(g) - int'(last_g);
		if (dg < 0)
			dg = -dg;
		if (closed) begin
			taps = win_taps;
			win_taps = '0;
			if (da > int'(regs.fall_jump) || dg > int'(regs.fall_jump)) begin
				assist = 1'b1;
				r.mode_event = EV_ENGAGED;
			end else if (taps <= 2 && !assist) begin
				assist = 1'b1;
				r.mode_event = EV_ENGAGED;
			end else if (taps >= 3 && assist) begin
				assist = 1'b0;
				r.mode_event = EV_DISENGAGE;
			end
		end
		if (da < int'(regs.still_band) && dg < int'(regs.still_band)) begin
			if (still_run != CNT_MAX)
				still_run = still_run + 1'b1;
		end else begin
			still_run = '0;
		end
		if (still_run >= regs.idle_limit && !assist) begin
			assist = 1'b1;
			r.mode_event = EV_IDLE;
			still_run = '0;
		end
		last_a = a;
		last_g = g;
		r.assist_on = assist;
		if (!assist) begin
			if (int'(a) > 0 && int'(a) <= int'(OBST_FAR)) begin
				if (int'(a) > int'(OBST_MID))
					r.alert.obstacle_level = OBST_QUARTER;
				else if (int'(a) > int'(OBST_NEAR))
					r.alert.obstacle_level = OBST_HALF;
				else
					r.alert.obstacle_level = OBST_FULL;
			end
			if (int'(g) >= int'(LEDGE_SIREN_MIN))
				r.alert.ledge_level = LEDGE_SIREN;
			else if (int'(g) >= int'(LEDGE_FULL_MIN))
				r.alert.ledge_level = LEDGE_FULL;
			else if (int'(g) >= int'(LEDGE_HALF_MIN))
				r.alert.ledge_level = LEDGE_HALF;
			else if (int'(g) >= int'(LEDGE_QUARTER_MIN))
				r.alert.ledge_level = LEDGE_QUARTER;
			r.alert.display_update = 1'b1;
			r.alert.ahead_display = shown_cm(a);
			r.alert.ground_display = shown_cm(g);
		end
		r.taps_seen = taps;
		return 1'b1;
	endfunction

	function automatic string show(input result_t r);
		return $sformatf("assist=%0d event=%0d obst=%0d ledge=%0d upd=%0d ahead=%0d ground=%0d taps=%0d",
			r.assist_on, r.mode_event, r.alert.obstacle_level, r.alert.ledge_level,
			r.alert.display_update, r.alert.ahead_display, r.alert.ground_display, r.taps_seen);
	endfunction

	always @(posedge clk) begin
		result_t r;
		if (arst_n && in_valid && !in_stall) begin
			if (func == FUNC_TAP)
				n_taps++;
			else
				n_steps++;
			if (predict_alert(func, ahead_distance, ground_distance, r)) begin
				alert_q.push_back(pin_en ? pin_res : r);
				case (r.mode_event)
					EV_ENGAGED: n_engaged++;
					EV_IDLE: n_idle++;
					EV_DISENGAGE: n_released++;
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		got = {assist_on, mode_event, obstacle_level, ledge_level, display_update,
			ahead_display, ground_display, taps_seen};
		if (arst_n && out_valid && !out_stall) begin
			n_checked++;
			if (alert_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("Unexpected result at %0t: %s", $time, show(got));
			end else begin
				want = alert_q.pop_front();
				if (got !== want) begin
					n_bad++;
					if (n_bad <= 10) begin
						$display("Mismatch at %0t", $time);
						$display("  expected %s", show(want));
						$display("  actual   %s", show(got));
					end
				end
			end
		end
		if (!arst_n || !stall_on) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timed out with %0d results outstanding.", alert_q.size());
			$display("** walking_aid_alert_controller: FAILED **");
			$finish;
		end
	end

	task automatic send_item(input logic f, input dist_t a, input dist_t g, input logic pin,
			input result_t pv);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		ahead_distance <= a;
		ground_distance <= g;
		pin_en <= pin;
		pin_res <= pv;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (alert_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TAP_WINDOW_TICKS: regs.tap_window_ticks = val[7:0];
			REG_FALL_JUMP: regs.fall_jump = val;
			REG_STILL_BAND: regs.still_band = val;
			REG_IDLE_LIMIT: regs.idle_limit = val[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic dist_t any_dist();
		return dist_t'(int'($urandom_range(0, 16399)) - 16);
	endfunction

	function automatic dist_t next_dist(input dist_t prev, input bit standing);
		int v;
		if (standing)
			v = int'(prev) + int'($urandom_range(0, 8)) - 4;
		else
			case ($urandom_range(0, 9))
				0: v = int'($urandom_range(0, 16399)) - 16;
				1: v = -16;
				2, 3, 4: v = int'(prev) + int'($urandom_range(0, 40)) - 20;
				5, 6: v = int'(prev) + int'($urandom_range(0, 800)) - 400;
				7: v = 16383;
				default: v = int'($urandom_range(0, 640));
			endcase
		if (v < -16)
			v = -16;
		if (v > 16383)
			v = 16383;
		return dist_t'(v);
	endfunction

	initial begin
		int ph;
		int k;
		int sent;
		int taps_n;
		int steps_n;
		int span;
		bit standing;
		cfg_t pick;
		dist_t drv_a;
		dist_t drv_g;
		drv_a = '0;
		drv_g = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		n_settings = 1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				wait_idle();
				write_reg(plan[i].idx, plan[i].val);
				n_settings++;
			end else begin
				send_item(plan[i].f, plan[i].a, plan[i].g, plan[i].pin, plan[i].res);
				if (plan[i].f == FUNC_STEP) begin
					drv_a = plan[i].a;
					drv_g = plan[i].g;
				end
			end
		end

		for (ph = 0; ph < N_PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: pick = '{RST_TAP_WINDOW_TICKS, RST_FALL_JUMP, RST_STILL_BAND, RST_IDLE_LIMIT};
				1: pick = '{8'd255, 14'd16383, 14'd16383, 8'd255};
				2: pick = '{8'd1, 14'd0, 14'd0, 8'd1};
				3: pick = '{8'd0, 14'd320, 14'd32, 8'd0};
				default: pick = '{8'($urandom_range(1, 10)), 14'($urandom_range(0, 1200)),
					14'($urandom_range(0, 64)), 8'($urandom_range(1, 25))};
			endcase
			write_reg(REG_TAP_WINDOW_TICKS, CFG_W'(pick.tap_window_ticks));
			write_reg(REG_FALL_JUMP, pick.fall_jump);
			write_reg(REG_STILL_BAND, pick.still_band);
			write_reg(REG_IDLE_LIMIT, CFG_W'(pick.idle_limit));
			n_settings++;
			if (ph == N_PHASES - 1) begin
				gaps_on = 1'b0;
				stall_on = 1'b0;
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				standing = ($urandom_range(0, 2) == 0);
				if (ph == 2 && sent == 0)
					taps_n = 256 + $urandom_range(0, 12);
				else if ($urandom_range(0, 1) == 0)
					taps_n = 0;
				else
					taps_n = $urandom_range(1, 5);
				span = int'(regs.tap_window_ticks);
				if (int'(regs.idle_limit) > span)
					span = int'(regs.idle_limit);
				if ($urandom_range(0, 1) == 0)
					steps_n = $urandom_range(1, 6);
				else
					steps_n = $urandom_range(1, span + 4);
				for (k = 0; k < taps_n; k++) begin
					send_item(FUNC_TAP, any_dist(), any_dist(), 1'b0, '0);
					sent++;
				end
				for (k = 0; k < steps_n; k++) begin
					drv_a = next_dist(drv_a, standing);
					drv_g = next_dist(drv_g, standing);
					send_item(FUNC_STEP, drv_a, drv_g, 1'b0, '0);
					sent++;
				end
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		$display("Drove %0d step and %0d tap items over %0d register settings; %0d results checked.",
			n_steps, n_taps, n_settings, n_checked);
		$display("Mode changes: %0d engaged by fall or taps, %0d engaged by idle, %0d disengaged.",
			n_engaged, n_idle, n_released);
		if (n_bad == 0 && alert_q.size() == 0)
			$display("** walking_aid_alert_controller: PASSED **");
		else
			$display("** walking_aid_alert_controller: FAILED **");
		$finish;
	end

endmodule
